>>> sv/teaa_pkg.sv
// Package for the two-ended arena allocator: widths, codes, item types and states.
`default_nettype none

package teaa_pkg;

	// Alignment of every block; must be a power of two.
	localparam int ALIGN_BYTES = 4;
	localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
	localparam int DEF_REGION_MAX_BYTES = 4096;

	localparam int PTR_W = 13;
	localparam int SIZE_W = 16;
	localparam int ADDR_W = 12;
	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;
	localparam int AMT_W = SIZE_W + 1;
	localparam int BASE_W = PTR_W + 1;
	localparam int HDR_W = PTR_W + 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [PTR_W-1:0] RST_REGION_BYTES = PTR_W'(4096);
	localparam logic [PTR_W-1:0] RST_RESERVED_BYTES = PTR_W'(64);

	localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TEMP_ALLOC = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEMP_FREE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TEMP_FREE_ALL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESET = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_INIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BYTES = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   result_address;
		logic [PTR_W-1:0]    free_bytes;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MARK,
		S_WALK_RD,
		S_WALK_CHK,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

>>> sv/two_ended_arena_allocator_unit.sv
// Two-ended arena allocator: pointer registers, header memory and the command sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | req_valid/req_ready  | cmd, size, address
//   rsp     | out       | rsp_valid/rsp_ready  | status, result_address, free_bytes
//   cfg     | in        | cfg_we (no wait)     | cfg_index, cfg_data
//
// Alloc, temp alloc, free-all, reset and a rejected free go from acceptance via S_EXEC
// and S_RESP to the response register. A temp free of a valid address adds S_MARK
// and S_WALK_RD/S_WALK_CHK per merged block; a merge reaching the region end goes
// straight to S_RESP. The header walk issues one memory read and one check per block.
// The header memory needs no clearing pass, so the block is ready right after arst_n.
// A waiting response does not stop the next request; only a second finished response
// waits for the response register to drain.
`default_nettype none

module two_ended_arena_allocator_unit
	import teaa_pkg::*;
#(
	parameter int REGION_MAX_BYTES = DEF_REGION_MAX_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PTR_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp
);

	localparam int HDR_DEPTH = REGION_MAX_BYTES / ALIGN_BYTES;
	localparam int IDX_W = $clog2(HDR_DEPTH);
	localparam int SAT_W = ($clog2(REGION_MAX_BYTES + 1) > BASE_W) ?
		$clog2(REGION_MAX_BYTES + 1) : BASE_W;
	localparam logic [PTR_W-1:0] PTR_ALIGN_MASK = PTR_W'(ALIGN_BYTES - 1);
	localparam logic [AMT_W-1:0] AMT_ALIGN_MASK = AMT_W'(ALIGN_BYTES - 1);
	localparam logic [SAT_W-1:0] SAT_ALIGN_MASK = SAT_W'(ALIGN_BYTES - 1);
	localparam logic [ADDR_W-1:0] ADDR_ALIGN_MASK = ADDR_W'(ALIGN_BYTES - 1);

	function automatic logic [SAT_W-1:0] sat_bytes(input logic [PTR_W-1:0] r);
		logic [SAT_W-1:0] rw;
		rw = SAT_W'(r);
		return (rw > SAT_W'(REGION_MAX_BYTES)) ? SAT_W'(REGION_MAX_BYTES) : rw;
	endfunction

	function automatic logic [PTR_W-1:0] end_of(input logic [PTR_W-1:0] r);
		logic [SAT_W-1:0] rs;
		rs = sat_bytes(r);
		return (rs == '0) ? '0 : (PTR_W'(rs - SAT_W'(1)) & ~PTR_ALIGN_MASK);
	endfunction

	function automatic logic [BASE_W-1:0] base_of(input logic [PTR_W-1:0] r);
		logic [SAT_W-1:0] sum;
		sum = sat_bytes(r) + SAT_ALIGN_MASK;
		return BASE_W'(sum & ~SAT_ALIGN_MASK);
	endfunction

	function automatic logic [IDX_W-1:0] idx_of(input logic [PTR_W-1:0] ptr);
		return IDX_W'(ptr >> ALIGN_LG);
	endfunction

	localparam logic [PTR_W-1:0] END_RST = end_of(RST_REGION_BYTES);
	localparam logic [BASE_W-1:0] BASE_RST = base_of(RST_RESERVED_BYTES);
	localparam logic OK_RST = (RST_REGION_BYTES != '0) && (BASE_RST <= BASE_W'(END_RST));

	state_t              state_q, state_d;
	logic [PTR_W-1:0]    region_q, region_d;
	logic [PTR_W-1:0]    reserved_q, reserved_d;
	logic [PTR_W-1:0]    end_q, end_d;
	logic [BASE_W-1:0]   base_q, base_d;
	logic                init_ok_q, init_ok_d;
	logic [PTR_W-1:0]    perm_next_q, perm_next_d;
	logic [PTR_W-1:0]    temp_end_q, temp_end_d;
	req_t                req_q, req_d;
	logic [IDX_W-1:0]    hdr_idx_q, hdr_idx_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [ADDR_W-1:0]   result_q, result_d;
	rsp_t                rsp_q, rsp_d;
	logic                rsp_valid_q, rsp_valid_d;

	// Header word: free mark on top, rounded block size below. Entries are never cleared:
	// the walk only reads the header at the temporary end, which a temp alloc has always
	// written since the last reinit, so stale entries are never observed.
	logic [HDR_W-1:0]    hdr_mem [HDR_DEPTH];
	logic [HDR_W-1:0]    mem_rdata_q;
	logic                mem_we, mem_re;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [HDR_W-1:0]    mem_wdata;

	logic                room_ok;
	logic [PTR_W-1:0]    avail;
	logic [AMT_W-1:0]    amt_perm, amt_temp;
	logic [PTR_W-1:0]    new_temp_end;
	logic                addr_ok, hdr_in_range;
	logic [PTR_W-1:0]    hdr_ptr;
	logic                walk_free;
	logic [PTR_W-1:0]    walk_size;
	logic [BASE_W-1:0]   walk_next;
	logic [PTR_W-1:0]    free_now;

	assign room_ok = temp_end_q >= perm_next_q;
	assign avail = temp_end_q - perm_next_q;
	assign amt_perm = (AMT_W'(req_q.size) + AMT_ALIGN_MASK) & ~AMT_ALIGN_MASK;
	assign amt_temp = (AMT_W'(req_q.size) + AMT_W'(ALIGN_BYTES) + AMT_ALIGN_MASK)
		& ~AMT_ALIGN_MASK;
	assign new_temp_end = temp_end_q - PTR_W'(amt_temp);

	assign addr_ok = (req_q.address >= ADDR_W'(ALIGN_BYTES))
		&& ((req_q.address & ADDR_ALIGN_MASK) == '0);
	assign hdr_ptr = PTR_W'(req_q.address - ADDR_W'(ALIGN_BYTES));
	assign hdr_in_range = (hdr_ptr >= temp_end_q) && (hdr_ptr < end_q);

	assign walk_free = mem_rdata_q[HDR_W-1];
	assign walk_size = mem_rdata_q[PTR_W-1:0];
	assign walk_next = BASE_W'(temp_end_q) + BASE_W'(walk_size);

	assign free_now = (init_ok_q && room_ok) ? avail : '0;

	assign end_d = end_of(region_d);
	assign base_d = base_of(reserved_d);
	assign init_ok_d = (region_d != '0) && (base_d <= BASE_W'(end_d));

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		region_d = region_q;
		reserved_d = reserved_q;
		perm_next_d = perm_next_q;
		temp_end_d = temp_end_q;
		req_d = req_q;
		hdr_idx_d = hdr_idx_q;
		status_d = status_q;
		result_d = result_q;
		rsp_d = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		req_ready = 1'b0;
		mem_we = 1'b0;
		mem_waddr = hdr_idx_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = hdr_idx_q;

		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d = req;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = STATUS_OK;
				result_d = '0;
				state_d = S_RESP;
				if (!init_ok_q) begin
					status_d = STATUS_NOT_INIT;
				end else begin
					unique case (req_q.cmd)
						CMD_ALLOC: begin
							if (!room_ok || amt_perm > AMT_W'(avail)) begin
								status_d = STATUS_NO_MEMORY;
							end else begin
								result_d = ADDR_W'(perm_next_q);
								perm_next_d = perm_next_q + PTR_W'(amt_perm);
							end
						end
						CMD_TEMP_ALLOC: begin
							if (!room_ok || amt_temp > AMT_W'(avail)) begin
								status_d = STATUS_NO_MEMORY;
							end else begin
								temp_end_d = new_temp_end;
								mem_we = 1'b1;
								mem_waddr = idx_of(new_temp_end);
								mem_wdata = {1'b0, PTR_W'(amt_temp)};
								result_d = ADDR_W'(new_temp_end + PTR_W'(ALIGN_BYTES));
							end
						end
						CMD_TEMP_FREE: begin
							// Fetch the header, then set its free mark in the next cycle.
							if (addr_ok && hdr_in_range) begin
								mem_re = 1'b1;
								mem_raddr = idx_of(hdr_ptr);
								hdr_idx_d = idx_of(hdr_ptr);
								state_d = S_MARK;
							end
						end
						CMD_TEMP_FREE_ALL: begin
							temp_end_d = end_q;
						end
						CMD_RESET: begin
							perm_next_d = base_q[PTR_W-1:0];
							temp_end_d = end_q;
						end
						default: begin
						end
					endcase
				end
			end
			S_MARK: begin
				mem_we = 1'b1;
				mem_waddr = hdr_idx_q;
				mem_wdata = {1'b1, mem_rdata_q[PTR_W-1:0]};
				state_d = S_WALK_RD;
			end
			S_WALK_RD: begin
				if (temp_end_q >= end_q) begin
					state_d = S_RESP;
				end else begin
					mem_re = 1'b1;
					mem_raddr = idx_of(temp_end_q);
					state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				// Merge the block at the temporary end if it is free and not empty.
				if (!walk_free || walk_size == '0) begin
					state_d = S_RESP;
				end else if (walk_next >= BASE_W'(end_q)) begin
					temp_end_d = end_q;
					state_d = S_RESP;
				end else begin
					temp_end_d = walk_next[PTR_W-1:0];
					state_d = S_WALK_RD;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d.status = status_q;
					rsp_d.result_address = result_q;
					rsp_d.free_bytes = free_now;
					rsp_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A register write reinitializes the pointers from the new values.
		if (cfg_we) begin
			unique case (cfg_index)
				REG_REGION_BYTES: region_d = cfg_data;
				REG_RESERVED_BYTES: reserved_d = cfg_data;
				default: begin
				end
			endcase
			perm_next_d = base_d[PTR_W-1:0];
			temp_end_d = end_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			region_q <= RST_REGION_BYTES;
			reserved_q <= RST_RESERVED_BYTES;
			end_q <= END_RST;
			base_q <= BASE_RST;
			init_ok_q <= OK_RST;
			perm_next_q <= BASE_RST[PTR_W-1:0];
			temp_end_q <= END_RST;
		end else begin
			state_q <= state_d;
			rsp_valid_q <= rsp_valid_d;
			region_q <= region_d;
			reserved_q <= reserved_d;
			end_q <= end_d;
			base_q <= base_d;
			init_ok_q <= init_ok_d;
			perm_next_q <= perm_next_d;
			temp_end_q <= temp_end_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		hdr_idx_q <= hdr_idx_d;
		status_q <= status_d;
		result_q <= result_d;
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) hdr_mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= hdr_mem[mem_raddr];
	end

endmodule

`default_nettype wire
